@@ rtl/bsort_pkg.sv @@
// shared constants and types of the batch bubble sorter
package bsort_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]         rd_addr;
   } store_cmd_type;

endpackage

@@ rtl/bsort_store.sv @@
// value store: one write port and one registered read port
module bsort_store
   import bsort_pkg::*;
(
   input  logic                     clock,
   input  store_cmd_type            cmd,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [MAX_ENTRIES];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/array_bubble_sort_unit.sv @@
// top level of the batch bubble sorter
//
// Requests carry one signed 32-bit sample each; req_final_item closes the batch.
// Up to MAX_ENTRIES samples are stored; extra samples are dropped and the
// overflow flag is raised on every result of that batch.
// A non-final request gives no result.
// After the final request the store is bubble-sorted in place through one
// compare unit and one store with one write and one read port: a pass over
// L neighbor pairs runs through START, LOAD, one STEP per pair and END, the
// first pass has L = count - 1, each pass is one pair shorter, and sorting
// ends after a pass with no swap or after the one-pair pass.
// Results then leave in order, each read anew after the one before is taken;
// while rsp_stall is high the result holds. end_of_batch marks the last one.
// req_stall stays high from the final request until the last result is taken.
// csr_write_en writes the sort direction (1 = descending); write it only when
// the block is idle.
// A synchronous reset empties the batch, clears the overflow flag and the
// direction; the store contents need no clearing.
module array_bubble_sort_unit
   import bsort_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_final_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_end_of_batch,
   output logic                     rsp_overflow,
   input  logic                     csr_write_en,
   input  logic                     csr_write_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_END    = 3'd4;
   localparam logic [2:0] ST_OUT_RD = 3'd5;
   localparam logic [2:0] ST_OUT_LD = 3'd6;
   localparam logic [2:0] ST_OUT_WT = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic                     dropped_ff, dropped_in;
   logic                     desc_ff;
   logic [IDX_W-1:0]         limit_ff, limit_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     changed_ff, changed_in;
   logic signed [DATA_W-1:0] held_ff, held_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   store_cmd_type            cmd;
   logic signed [DATA_W-1:0] rd_data;
   logic                     req_take;
   logic                     rsp_take;
   logic                     out_of_order;
   logic [CNT_W-1:0]         count_next;
   logic                     last_out;

   bsort_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // shared compare unit
   assign out_of_order = desc_ff ? (rd_data > held_ff) : (held_ff > rd_data);

   assign last_out = (({1'b0, idx_ff} + CNT_W'(1)) == fill_ff);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      changed_in   = changed_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      cmd.wr_en    = 1'b0;
      cmd.wr_addr  = idx_ff;
      cmd.wr_data  = held_ff;
      cmd.rd_addr  = idx_ff;
      count_next   = fill_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd.wr_addr = fill_ff[IDX_W-1:0];
            cmd.wr_data = req_sample;
            if (req_take) begin
               if (fill_ff < CNT_W'(MAX_ENTRIES)) begin
                  cmd.wr_en  = 1'b1;
                  count_next = fill_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               fill_in = count_next;
               if (req_final_item) begin
                  limit_in = IDX_W'(count_next - CNT_W'(1));
                  idx_in   = '0;
                  if (count_next > CNT_W'(1)) begin
                     state_in = ST_START;
                  end else begin
                     state_in = ST_OUT_RD;
                  end
               end
            end
         end
         ST_START: begin
            cmd.rd_addr = '0;
            changed_in  = 1'b0;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.rd_addr = IDX_W'(1);
            held_in     = rd_data;
            idx_in      = '0;
            state_in    = ST_STEP;
         end
         ST_STEP: begin
            cmd.rd_addr = idx_ff + IDX_W'(2);
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff;
            if (out_of_order) begin
               cmd.wr_data = rd_data;
               changed_in  = 1'b1;
            end else begin
               cmd.wr_data = held_ff;
               held_in     = rd_data;
            end
            if ((idx_ff + IDX_W'(1)) == limit_ff) begin
               state_in = ST_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_END: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = limit_ff;
            cmd.wr_data = held_ff;
            limit_in    = limit_ff - IDX_W'(1);
            idx_in      = '0;
            if (changed_ff && (limit_ff > IDX_W'(1))) begin
               state_in = ST_START;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_addr = idx_ff;
            state_in    = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_last_in  = last_out;
            rsp_ovf_in   = dropped_ff;
            state_in     = ST_OUT_WT;
         end
         ST_OUT_WT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         changed_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff   <= changed_in;
         if (csr_write_en) begin
            desc_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      idx_ff       <= idx_in;
      held_ff      <= held_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_batch = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill count beyond capacity");

   a_rsp_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT_WT))
      else $error("result shown outside the output wait state");

   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (fill_ff == '0) && !dropped_ff && !req_stall)
      else $error("batch not emptied after its last result");

   a_sort_write_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (state_ff != ST_IDLE)) |-> ({1'b0, cmd.wr_addr} < fill_ff))
      else $error("sort writes beyond the stored entries");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_LD) |-> ({1'b0, idx_ff} < fill_ff))
      else $error("output index beyond the stored entries");
`endif

endmodule
